// ===== hw/rtl/josephus_survivor_macros.svh =====
// Assertion macros used by the checker file.
`ifndef JOSEPHUS_SURVIVOR_MACROS_SVH
`define JOSEPHUS_SURVIVOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/jos_pkg.sv =====
package jos_pkg;

  // Field widths of the two channels
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned SURV_W  = 11;
  // Width wide enough to compare a count with any capacity below 2**17
  localparam int unsigned CAP_W   = 17;
  // Partial remainder of the shift-subtract divider
  localparam int unsigned DREM_W  = COUNT_W + 1;
  localparam int unsigned DBIT_W  = 4;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_INIT   = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_LOAD   = 7'b0001000,
    ST_CHAIN  = 7'b0010000,
    ST_UNLINK = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/josephus_survivor.sv =====
// Channel  Handshake                 Word
// -------  ------------------------  ---------------------------
// in       in_valid_i / in_ready_o   count_i [10:0], step_i [15:0]
// out      out_valid_o / out_ready_i survivor_o [10:0], error_o
//
// A bad count (zero or above MAX_COUNT) skips to the done state and leaves as an error word.
// Otherwise a word writes its n ring links, then each of the n-1 eliminations runs a
// 16-bit shift-subtract remainder giving adv = (m-1) mod r, then one link-RAM read
// per link walked.
// Reset returns the sequencer to idle; the link RAM is not cleared.
// in_ready_o is high only when idle; a stalled result holds in the output register.
module josephus_survivor
  import jos_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [COUNT_W-1:0]  count_i,
  input  logic [STEP_W-1:0]   step_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SURV_W-1:0]   survivor_o,
  output logic                error_o
);

  localparam int unsigned AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int unsigned CW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [STEP_W-1:0]    mdec_q, mdec_d;
  logic                 err_q, err_d;
  logic [AW-1:0]        wp_q, wp_d;
  logic [COUNT_W-1:0]   rcnt_q, rcnt_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [STEP_W-1:0]    dv_q, dv_d;
  logic [DREM_W-1:0]    drem_q, drem_d;
  logic [DBIT_W-1:0]    dbit_q, dbit_d;
  logic [COUNT_W-1:0]   adv_q, adv_d;
  logic                 out_valid_q, out_valid_d;
  logic [SURV_W-1:0]    survivor_q, survivor_d;
  logic                 error_q, error_d;

  logic [AW-1:0]        link_mem [MAX_COUNT];
  logic [AW-1:0]        rd_data_q;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        wr_data;

  logic [DREM_W-1:0]    div_try;
  logic [DREM_W-1:0]    div_sub;
  logic                 div_ge;
  logic [DREM_W-1:0]    div_next;
  logic                 init_last;
  logic                 in_bad;

  // Shared shift-subtract unit: one remainder bit per cycle
  assign div_try  = {drem_q[DREM_W-2:0], dv_q[STEP_W-1]};
  assign div_ge   = div_try >= {1'b0, rcnt_q};
  assign div_sub  = div_try - {1'b0, rcnt_q};
  assign div_next = div_ge ? div_sub : div_try;

  assign init_last = (CW'(idx_q) + CW'(1)) == CW'(count_q);
  assign in_bad    = (count_i == '0) || (CAP_W'(count_i) > CAP_W'(MAX_COUNT));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mdec_d      = mdec_q;
    err_d       = err_q;
    wp_d        = wp_q;
    rcnt_d      = rcnt_q;
    idx_d       = idx_q;
    dv_d        = dv_q;
    drem_d      = drem_q;
    dbit_d      = dbit_q;
    adv_d       = adv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    survivor_d  = survivor_q;
    error_d     = error_q;
    rd_en       = 1'b0;
    rd_addr     = rd_data_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          count_d = count_i;
          mdec_d  = (step_i == '0) ? '0 : step_i - STEP_W'(1);
          err_d   = in_bad;
          idx_d   = '0;
          state_d = in_bad ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: begin
        // Write one ring link per cycle
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = init_last ? '0 : AW'(idx_q + AW'(1));
        idx_d   = AW'(idx_q + AW'(1));
        if (init_last) begin
          wp_d   = AW'(count_q - COUNT_W'(1));
          rcnt_d = count_q;
          dv_d   = mdec_q;
          drem_d = '0;
          dbit_d = '0;
          state_d = (count_q == COUNT_W'(1)) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        drem_d = div_next;
        dv_d   = dv_q << 1;
        dbit_d = dbit_q + DBIT_W'(1);
        if (dbit_q == DBIT_W'(STEP_W - 1)) begin
          adv_d   = div_next[COUNT_W-1:0];
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Fetch the link after the walker
        rd_en   = 1'b1;
        rd_addr = wp_q;
        state_d = ST_CHAIN;
      end
      ST_CHAIN: begin
        // Follow one link a cycle; the last fetch reads past the victim
        rd_en   = 1'b1;
        rd_addr = rd_data_q;
        if (adv_q == '0) begin
          state_d = ST_UNLINK;
        end else begin
          wp_d  = rd_data_q;
          adv_d = adv_q - COUNT_W'(1);
        end
      end
      ST_UNLINK: begin
        // Drop the victim from the ring
        wr_en   = 1'b1;
        wr_addr = wp_q;
        wr_data = rd_data_q;
        rcnt_d  = rcnt_q - COUNT_W'(1);
        dv_d    = mdec_q;
        drem_d  = '0;
        dbit_d  = '0;
        state_d = (rcnt_q == COUNT_W'(2)) ? ST_DONE : ST_DIV;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          survivor_d  = err_q ? '0 : SURV_W'(wp_q) + SURV_W'(1);
          error_d     = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Link RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= link_mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      rcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wp_q        <= wp_d;
      rcnt_q      <= rcnt_d;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    mdec_q     <= mdec_d;
    err_q      <= err_d;
    idx_q      <= idx_d;
    dv_q       <= dv_d;
    drem_q     <= drem_d;
    dbit_q     <= dbit_d;
    adv_q      <= adv_d;
    survivor_q <= survivor_d;
    error_q    <= error_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign survivor_o  = survivor_q;
  assign error_o     = error_q;

endmodule

// ===== hw/rtl/josephus_chk.sv =====
`include "josephus_survivor_macros.svh"

module josephus_chk
  import jos_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [COUNT_W-1:0] count_i,
  input logic [STEP_W-1:0]  step_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [SURV_W-1:0]  survivor_o,
  input logic               error_o
);

  // Hold a stalled result word
  `JS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(survivor_o) && $stable(error_o), "result changed while stalled")

  // An error word carries survivor zero
  `JS_ASSERT_IMP(a_err_zero, out_valid_o && error_o, survivor_o == '0, "error word with non-zero survivor")

  // A good word names a real position
  `JS_ASSERT_IMP(a_ok_pos, out_valid_o && !error_o, survivor_o != '0, "good word with survivor zero")

  // Busy straight after taking a word
  `JS_ASSERT_NXT(a_busy, in_valid_i && in_ready_o, !in_ready_o, "ready right after accepting a word")

endmodule

bind josephus_survivor josephus_chk u_chk (.*);
